### src/clfd_pkg.sv
// ----------------------------------------------------------------------------
// clfd_pkg
// Shared types, result codes and the CRC-16/KERMIT byte update for the
// length-prefixed frame decoder.
// ----------------------------------------------------------------------------
package clfd_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
    } result_t;

    // reflected crc, one byte folded in, lsb first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### src/clfd_in_stage.sv
// ----------------------------------------------------------------------------
// clfd_in_stage
// Input register: holds one received byte until the decoder core takes it.
// ----------------------------------------------------------------------------
module clfd_in_stage import clfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
    end

endmodule

### src/clfd_core.sv
// ----------------------------------------------------------------------------
// clfd_core
// Frame state, length counter, running CRC; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module clfd_core import clfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic [7:0] start_byte,
    input  logic       out_free,
    output logic       take,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC_HI  = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic        has_result;
    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] left_dec;

    assign has_result = (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CRC_LO);
    assign take       = item_valid && (!has_result || out_free);
    assign res_valid  = take && has_result;

    assign crc_upd  = crc_add_byte((phase_reg == PH_LEN_HI) ? 16'h0000 : crc_reg,
                                   item_byte);
    assign len_full = {bytes_left_reg[15:8], item_byte};
    assign left_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        res.kind         = KIND_DATA;
        res.payload_byte = 8'h00;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                crc_next        = crc_upd;
                bytes_left_next = {item_byte, 8'h00};
                phase_next      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                crc_next        = crc_upd;
                bytes_left_next = len_full;
                phase_next      = (len_full == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                crc_next         = crc_upd;
                bytes_left_next  = left_dec;
                if (left_dec == 16'd0)
                    phase_next = PH_CRC_HI;
                res.kind         = KIND_DATA;
                res.payload_byte = item_byte;
            end
            PH_CRC_HI:
            begin
                crc_high_next = item_byte;
                phase_next    = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                res.kind   = ({crc_high_reg, item_byte} == crc_reg) ? KIND_GOOD
                                                                     : KIND_BAD;
                phase_next = PH_HUNT;
            end
            default:
            begin
                // hunting; unused codes behave the same
                phase_next = PH_HUNT;
                if (item_byte == start_byte)
                begin
                    phase_next      = PH_LEN_HI;
                    crc_next        = 16'h0000;
                    bytes_left_next = 16'h0000;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= 16'h0000;
            crc_reg        <= 16'h0000;
            crc_high_reg   <= 8'h00;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
        end
    end

endmodule

### src/clfd_out_stage.sv
// ----------------------------------------------------------------------------
// clfd_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module clfd_out_stage import clfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  result_t    res,
    output logic       out_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign kind         = res_reg.kind;
    assign payload_byte = res_reg.payload_byte;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

endmodule

### src/crc16_length_frame_decoder.sv
// ----------------------------------------------------------------------------
// crc16_length_frame_decoder
// Length-prefixed frame decoder with CRC-16/KERMIT check.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction, one byte per clock unless stalled.
// A byte passes an input register, the frame logic (state, 16-bit length
// counter and an unrolled eight-bit CRC update), then a result register. A
// result is held there until the sink takes it. The input stalls only when
// both registers hold a transaction and the sink is not ready. Bytes are
// dropped until one equals start_byte; then come a big-endian 16-bit
// length, the payload (each byte delivered as kind 0) and the CRC high
// byte first; the last CRC byte gives kind 1 (good) or kind 2 (mismatch)
// and hunting resumes.
// start_byte resets to 0x7e and is written through cfg_we / cfg_wdata.
// ----------------------------------------------------------------------------
module crc16_length_frame_decoder import clfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] payload_byte
);

    logic [7:0] start_byte_reg;
    logic       take;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       out_free;
    logic       res_valid;
    result_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_byte_reg <= 8'h7e;
        else if (cfg_we)
            start_byte_reg <= cfg_wdata;
    end

    clfd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    clfd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .start_byte (start_byte_reg),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    clfd_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte)
    );

endmodule
